@@ rtl/idar_pkg.sv @@
`default_nettype none
package idar_pkg;

    localparam int NUM_IDS_DEF    = 32;
    localparam int TIME_WIDTH_DEF = 32;

    localparam int MODE_W     = 2;
    localparam int ID_FIELD_W = 5;
    localparam int STATUS_W   = 2;
    localparam int EXPIRY_W   = 32;

    // request operation codes
    localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FREE  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TICK  = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] STAT_GRANT_FREE    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_GRANT_RECLAIM = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_NONE_EXPIRED  = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_DONE          = 2'd3;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_SCAN,
        CS_DRAIN,
        CS_FINISH
    } ctl_state_t;

    typedef struct packed {
        logic simple_op;   // execute free / tick / no-op and load result
        logic start_alloc; // clear scan trackers
        logic scan;        // read one entry, advance address
        logic finish;      // commit allocation and load result
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;    // result register can take a new result
        logic scan_end;    // scan address is at the last ID
    } dp_sts_t;

endpackage
`default_nettype wire

@@ rtl/id_allocator_age_reclaim.sv @@
`default_nettype none
// Transaction ID allocator over NUM_IDS IDs with timeout reclaim. Each request
// on the s_ channel is an allocate, free, one-tick time step or no-op (s_tuser);
// every request returns exactly one result on the m_ channel. Allocate grants
// the lowest free ID and stamps it with the tick counter; with every ID busy,
// the ID with the oldest stamp (lowest ID on a tie) is reclaimed when its age
// is strictly above expiry_ticks, otherwise status reports that none expired.
// Free, tick and no-op requests load the result register when accepted.
// For an allocate, the stamp memory is then read one entry per cycle by a
// single scan that finds both the lowest free ID and the oldest stamp,
// followed by a pipeline drain state and a commit state. The next
// request is taken once the result register is empty or drains in the same
// cycle. expiry_ticks resets to 5 and may be
// written at any time on the cfg_ channel (always ready); write it only while
// no request is in flight. No clearing pass is needed after reset.
module id_allocator_age_reclaim
    import idar_pkg::*;
#(
    parameter int NUM_IDS    = NUM_IDS_DEF,
    parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    // request channel
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [7:0]          s_tdata,  // [4:0] free_id, [7:5] zero
    input  wire logic [MODE_W-1:0]   s_tuser,  // [1:0] mode
    // result channel
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [7:0]               m_tdata,  // [4:0] granted_id, [7:5] zero
    output logic [STATUS_W-1:0]      m_tuser,  // [1:0] status
    // expiry_ticks write channel
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [EXPIRY_W-1:0] cfg_data
);

    dp_cmd_t               cmd;
    dp_sts_t               sts;
    logic [ID_FIELD_W-1:0] granted_id;

    // register write never stalls
    assign cfg_ready = 1'b1;

    // sequence each request: accept, and for an allocate scan, drain, commit
    idar_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .mode     (s_tuser),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // busy map, stamp memory, tick counter, scan trackers, result register
    idar_dp #(
        .NUM_IDS    (NUM_IDS),
        .TIME_WIDTH (TIME_WIDTH)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .sts        (sts),
        .mode       (s_tuser),
        .free_id    (s_tdata[ID_FIELD_W-1:0]),
        .cfg_we     (cfg_valid),
        .cfg_data   (cfg_data),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .granted_id (granted_id),
        .status     (m_tuser)
    );

    // pad the granted ID to a whole byte
    assign m_tdata = {{(8 - ID_FIELD_W){1'b0}}, granted_id};

endmodule
`default_nettype wire

@@ rtl/idar_ctrl.sv @@
`default_nettype none
module idar_ctrl
    import idar_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    input  wire logic [MODE_W-1:0] mode,
    output logic                   s_tready,
    input  wire dp_sts_t           sts,
    output dp_cmd_t                cmd
);

    ctl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CS_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            CS_IDLE: begin
                s_tready = sts.out_free;
                if (s_tvalid && sts.out_free) begin
                    if (mode == MODE_ALLOC) begin
                        cmd.start_alloc = 1'b1;
                        state_next      = CS_SCAN;
                    end else begin
                        cmd.simple_op = 1'b1;
                    end
                end
            end
            CS_SCAN: begin
                cmd.scan = 1'b1;
                if (sts.scan_end) begin
                    state_next = CS_DRAIN;
                end
            end
            // last entry is evaluated at the end of this cycle
            CS_DRAIN: begin
                state_next = CS_FINISH;
            end
            CS_FINISH: begin
                if (sts.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = CS_IDLE;
                end
            end
            default: begin
                state_next = CS_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

@@ rtl/idar_dp.sv @@
`default_nettype none
module idar_dp
    import idar_pkg::*;
#(
    parameter int NUM_IDS    = NUM_IDS_DEF,
    parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire dp_cmd_t               cmd,
    output dp_sts_t                    sts,
    input  wire logic [MODE_W-1:0]     mode,
    input  wire logic [ID_FIELD_W-1:0] free_id,
    input  wire logic                  cfg_we,
    input  wire logic [EXPIRY_W-1:0]   cfg_data,
    input  wire logic                  m_tready,
    output logic                       m_tvalid,
    output logic [ID_FIELD_W-1:0]      granted_id,
    output logic [STATUS_W-1:0]        status
);

    localparam int IDW   = $clog2(NUM_IDS);
    localparam int FIDW  = ((IDW > ID_FIELD_W) ? IDW : ID_FIELD_W) + 1;
    localparam int CMP_W = (TIME_WIDTH > EXPIRY_W) ? TIME_WIDTH : EXPIRY_W;

    logic [EXPIRY_W-1:0]   expiry_reg;
    logic [NUM_IDS-1:0]    busy_reg;
    logic [NUM_IDS-1:0]    vld_reg;
    logic [TIME_WIDTH-1:0] now_reg;
    logic [TIME_WIDTH-1:0] stamp_mem [NUM_IDS];

    logic [IDW-1:0]        cnt_reg;
    logic [TIME_WIDTH-1:0] rd_stamp_reg;
    logic                  rd_busy_reg;
    logic                  rd_vld_reg;
    logic [IDW-1:0]        rd_idx_reg;
    logic                  eval_reg;

    logic                  found_free_reg;
    logic [IDW-1:0]        free_idx_reg;
    logic [TIME_WIDTH-1:0] best_age_reg;
    logic [IDW-1:0]        oldest_reg;

    logic                  m_valid_reg;
    logic [ID_FIELD_W-1:0] granted_reg;
    logic [STATUS_W-1:0]   status_reg;

    logic [FIDW-1:0]       fid_ext;
    logic                  fid_ok;
    logic [TIME_WIDTH-1:0] age;
    logic                  reclaim;
    logic                  grant_en;
    logic [IDW-1:0]        grant_idx;

    assign fid_ext  = FIDW'(free_id);
    assign fid_ok   = fid_ext < FIDW'(NUM_IDS);
    // never-written stamps read as zero
    assign age      = now_reg - (rd_vld_reg ? rd_stamp_reg : '0);
    assign reclaim  = CMP_W'(best_age_reg) > CMP_W'(expiry_reg);
    assign grant_en = cmd.finish && (found_free_reg || reclaim);
    assign grant_idx = found_free_reg ? free_idx_reg : oldest_reg;

    assign sts.out_free = !m_valid_reg || m_tready;
    assign sts.scan_end = cnt_reg == IDW'(NUM_IDS - 1);

    assign m_tvalid   = m_valid_reg;
    assign granted_id = granted_reg;
    assign status     = status_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expiry_reg <= EXPIRY_W'(5);
            busy_reg   <= '0;
            vld_reg    <= '0;
            now_reg    <= '0;
        end else begin
            if (cfg_we) begin
                expiry_reg <= cfg_data;
            end
            if (cmd.simple_op) begin
                case (mode)
                    MODE_FREE: begin
                        if (fid_ok) begin
                            busy_reg[fid_ext[IDW-1:0]] <= 1'b0;
                        end
                    end
                    MODE_TICK: begin
                        now_reg <= now_reg + 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            if (grant_en) begin
                busy_reg[grant_idx] <= 1'b1;
                vld_reg[grant_idx]  <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (grant_en) begin
            stamp_mem[grant_idx] <= now_reg;
        end
        if (cmd.scan) begin
            rd_stamp_reg <= stamp_mem[cnt_reg];
        end
    end

    // scan address and one read stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            eval_reg <= 1'b0;
        end else begin
            eval_reg <= cmd.scan;
            if (cmd.start_alloc) begin
                cnt_reg <= '0;
            end else if (cmd.scan) begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.scan) begin
            rd_busy_reg <= busy_reg[cnt_reg];
            rd_vld_reg  <= vld_reg[cnt_reg];
            rd_idx_reg  <= cnt_reg;
        end
    end

    // lowest free ID and oldest stamp, first on a tie
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_free_reg <= 1'b0;
        end else if (cmd.start_alloc) begin
            found_free_reg <= 1'b0;
        end else if (eval_reg && !rd_busy_reg) begin
            found_free_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start_alloc) begin
            best_age_reg <= '0;
            oldest_reg   <= '0;
            free_idx_reg <= '0;
        end else if (eval_reg) begin
            if (!rd_busy_reg && !found_free_reg) begin
                free_idx_reg <= rd_idx_reg;
            end
            if (age > best_age_reg) begin
                best_age_reg <= age;
                oldest_reg   <= rd_idx_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.simple_op || cmd.finish) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.simple_op) begin
            granted_reg <= '0;
            status_reg  <= STAT_DONE;
        end else if (cmd.finish) begin
            if (found_free_reg) begin
                granted_reg <= ID_FIELD_W'(free_idx_reg);
                status_reg  <= STAT_GRANT_FREE;
            end else if (reclaim) begin
                granted_reg <= ID_FIELD_W'(oldest_reg);
                status_reg  <= STAT_GRANT_RECLAIM;
            end else begin
                granted_reg <= '0;
                status_reg  <= STAT_NONE_EXPIRED;
            end
        end
    end

    a_reclaim_all_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && status_reg == STAT_GRANT_RECLAIM |-> &busy_reg)
        else $error("reclaim result shown while an ID is free");

    a_eval_after_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        eval_reg |-> $past(cmd.scan))
        else $error("entry evaluated without a scan read");

    a_finish_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> !eval_reg && !cmd.scan)
        else $error("allocation committed before the scan drained");

endmodule
`default_nettype wire

@@ test/tb_id_allocator_age_reclaim.sv @@
`timescale 1ns / 1ps
module tb_id_allocator_age_reclaim;
    import idar_pkg::*;

    localparam int POOL_SIZE = NUM_IDS_DEF;
    // Mode value the block treats as a no-op; the package has no name for it.
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    // Cycles to let pass after the last result.
    localparam int SETTLE_CYCLES = POOL_SIZE + 8;
    localparam int DRAIN_LIMIT = 5000;
    localparam int PHASE_REQUESTS = 133;
    localparam int NUM_PHASES = 7;

    // Predicts the grant for every accepted request and checks results in order.
    class id_pool_scoreboard;
        bit [POOL_SIZE-1:0] busy;
        bit [TIME_WIDTH_DEF-1:0] stamp[POOL_SIZE];
        bit [TIME_WIDTH_DEF-1:0] now_tick;
        bit [EXPIRY_W-1:0] expiry;
        logic [ID_FIELD_W-1:0] expected_ids[$];
        logic [STATUS_W-1:0] expected_status[$];
        int error_count;
        int requests;
        int status_seen[4];

        function new();
            int k;
            busy = '0;
            for (k = 0; k < POOL_SIZE; k++) stamp[k] = '0;
            now_tick = '0;
            expiry = 32'd5;
            error_count = 0;
            requests = 0;
            for (k = 0; k < 4; k++) status_seen[k] = 0;
        endfunction

        function int pending();
            return expected_ids.size();
        endfunction

        function void note_request(logic [MODE_W-1:0] mode, logic [ID_FIELD_W-1:0] fid);
            logic [ID_FIELD_W-1:0] grant_id;
            logic [STATUS_W-1:0] status;
            bit [TIME_WIDTH_DEF-1:0] age;
            bit [TIME_WIDTH_DEF-1:0] best;
            int slot;
            int oldest;
            int k;
            grant_id = '0;
            status = STAT_DONE;
            case (mode)
                MODE_ALLOC: begin
                    slot = POOL_SIZE;
                    for (k = POOL_SIZE - 1; k >= 0; k--) if (!busy[k]) slot = k;
                    if (slot < POOL_SIZE) begin
                        busy[slot] = 1'b1;
                        stamp[slot] = now_tick;
                        grant_id = slot[ID_FIELD_W-1:0];
                        status = STAT_GRANT_FREE;
                    end else begin
                        // pool full: oldest stamp wins, lowest ID on a tie
                        best = '0;
                        oldest = 0;
                        for (k = 0; k < POOL_SIZE; k++) begin
                            age = now_tick - stamp[k];
                            if (age > best) begin
                                best = age;
                                oldest = k;
                            end
                        end
                        if (best > expiry) begin
                            stamp[oldest] = now_tick;
                            grant_id = oldest[ID_FIELD_W-1:0];
                            status = STAT_GRANT_RECLAIM;
                        end else begin
                            status = STAT_NONE_EXPIRED;
                        end
                    end
                end
                MODE_FREE: busy[fid] = 1'b0;
                MODE_TICK: now_tick = now_tick + 1'b1;
                default: ;
            endcase
            expected_ids.push_back(grant_id);
            expected_status.push_back(status);
            requests++;
        endfunction

        function void check_grant(logic [ID_FIELD_W-1:0] grant_id, logic [STATUS_W-1:0] status);
            logic [ID_FIELD_W-1:0] want_id;
            logic [STATUS_W-1:0] want_status;
            if (expected_ids.size() == 0) begin
                $display("%0t: result with nothing outstanding: granted_id %0d status %0d",
                         $time, grant_id, status);
                error_count++;
                return;
            end
            want_id = expected_ids.pop_front();
            want_status = expected_status.pop_front();
            if (grant_id !== want_id) begin
                $display("%0t: granted_id mismatch: expected %0d, actual %0d",
                         $time, want_id, grant_id);
                error_count++;
            end
            if (status !== want_status) begin
                $display("%0t: status mismatch: expected %0d, actual %0d",
                         $time, want_status, status);
                error_count++;
            end
            status_seen[want_status]++;
        endfunction

        function int pick_busy_id();
            int start;
            int k;
            start = $urandom_range(0, POOL_SIZE - 1);
            for (k = 0; k < POOL_SIZE; k++)
                if (busy[(start + k) % POOL_SIZE]) return (start + k) % POOL_SIZE;
            return start;
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn;
    logic s_tvalid;
    logic s_tready;
    logic [7:0] s_tdata;        // [4:0] free_id, [7:5] zero
    logic [MODE_W-1:0] s_tuser; // [1:0] mode
    logic m_tvalid;
    logic m_tready;
    logic [7:0] m_tdata;        // [4:0] granted_id, [7:5] zero
    logic [STATUS_W-1:0] m_tuser; // [1:0] status
    logic cfg_valid;
    logic cfg_ready;
    logic [EXPIRY_W-1:0] cfg_data;

    id_pool_scoreboard sb = new();
    bit quiet;          // when set, neither side idles
    int settings_tried;

    id_allocator_age_reclaim dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    always #5 aclk = ~aclk;

    function int pick_gap();
        return quiet ? 0 : $urandom_range(0, 10);
    endfunction

    // Present one request; entered and left at a falling edge. Valid stays
    // high on return so back-to-back requests need no drop in between.
    task automatic send_request(input logic [MODE_W-1:0] mode,
                                input logic [ID_FIELD_W-1:0] fid);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser = mode;
        s_tdata = {3'b000, fid};
        do @(posedge aclk); while (!s_tready);
        sb.note_request(mode, fid);
        @(negedge aclk);
    endtask

    // Drop valid and hold until every outstanding request has its result,
    // then let the block settle.
    task automatic drain_results();
        int waited;
        waited = 0;
        s_tvalid = 1'b0;
        while (sb.pending() > 0 && waited < DRAIN_LIMIT) begin
            @(negedge aclk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Write expiry_ticks; the block must be idle when this is called.
    task automatic write_expiry(input logic [EXPIRY_W-1:0] value);
        cfg_valid = 1'b1;
        cfg_data = value;
        do @(posedge aclk); while (!cfg_ready);
        sb.expiry = value;
        settings_tried++;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Send more requests than the pool size, mostly allocates with ticks mixed
    // in, so the pool can fill and then reclaims or refuses.
    task automatic fill_pool_run();
        int n;
        int i;
        n = $urandom_range(POOL_SIZE + 1, POOL_SIZE + 12);
        for (i = 0; i < n; i++) begin
            if ($urandom_range(0, 3) == 0) send_request(MODE_TICK, 5'($urandom()));
            else send_request(MODE_ALLOC, 5'($urandom()));
        end
    endtask

    // Mixed traffic; frees mostly target IDs that are actually held.
    task automatic churn_run();
        int n;
        int i;
        int pick;
        n = $urandom_range(10, 30);
        for (i = 0; i < n; i++) begin
            pick = $urandom_range(0, 19);
            if (pick < 8) send_request(MODE_ALLOC, 5'($urandom()));
            else if (pick < 13) send_request(MODE_FREE, 5'(sb.pick_busy_id()));
            else if (pick < 15) send_request(MODE_FREE, 5'($urandom()));
            else if (pick < 19) send_request(MODE_TICK, 5'($urandom()));
            else send_request(MODE_UNUSED, 5'($urandom()));
            // occasionally hold off until the block has caught up
            if ($urandom_range(0, 49) == 0) drain_results();
        end
    endtask

    // Age the held IDs, then allocate against them.
    task automatic age_then_alloc_run();
        int ticks;
        int allocs;
        ticks = $urandom_range(1, 10);
        allocs = $urandom_range(1, 4);
        repeat (ticks) send_request(MODE_TICK, 5'($urandom()));
        repeat (allocs) send_request(MODE_ALLOC, 5'($urandom()));
    endtask

    // Fully random requests, including the unused mode.
    task automatic noise_run();
        int n;
        n = $urandom_range(5, 15);
        repeat (n) send_request(2'($urandom_range(0, 3)), 5'($urandom()));
    endtask

    // Receiver: stall a random number of cycles per result, then check it.
    initial begin
        int gap;
        m_tready = 1'b0;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            gap = pick_gap();
            if (gap > 0) begin
                m_tready = 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready = 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            sb.check_grant(m_tdata[ID_FIELD_W-1:0], m_tuser);
            @(negedge aclk);
        end
    end

    initial begin
        logic [EXPIRY_W-1:0] expiry_plan[NUM_PHASES];
        int p;
        int phase_end;
        int pick;

        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        quiet = 1'b0;
        settings_tried = 0;
        repeat (12) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Directed: every operation, freeing idle IDs, field extremes, no-op mode.
        send_request(MODE_ALLOC, 5'd0);
        send_request(MODE_ALLOC, 5'd31);
        send_request(MODE_FREE, 5'd0);
        send_request(MODE_FREE, 5'd0);
        send_request(MODE_FREE, 5'd31);
        send_request(MODE_UNUSED, 5'd31);
        send_request(MODE_UNUSED, 5'd0);
        send_request(MODE_TICK, 5'd31);
        send_request(MODE_ALLOC, 5'd21);
        send_request(MODE_FREE, 5'd1);
        send_request(MODE_FREE, 5'b10101);
        send_request(MODE_FREE, 5'b01010);
        send_request(MODE_TICK, 5'd0);
        send_request(MODE_ALLOC, 5'd0);
        send_request(MODE_ALLOC, 5'd0);
        drain_results();

        // First phase runs on the reset expiry; the rest rewrite it.
        expiry_plan[0] = 32'd5;
        expiry_plan[1] = 32'd0;
        expiry_plan[2] = 32'd3;
        expiry_plan[3] = 32'hFFFF_FFFF;
        expiry_plan[4] = 32'd1;
        expiry_plan[5] = 32'($urandom_range(2, 12));
        expiry_plan[6] = $urandom();

        for (p = 0; p < NUM_PHASES; p++) begin
            if (p > 0) write_expiry(expiry_plan[p]);
            phase_end = sb.requests + PHASE_REQUESTS;
            while (sb.requests < phase_end) begin
                quiet = ($urandom_range(0, 4) == 0);
                pick = $urandom_range(0, 9);
                if (pick < 4) fill_pool_run();
                else if (pick < 7) churn_run();
                else if (pick < 9) age_then_alloc_run();
                else noise_run();
            end
            quiet = 1'b0;
            // hold every phase boundary until all results are back
            drain_results();
        end

        $display("Covered %0d requests across %0d expiry writes: %0d fresh grants, %0d reclaims,",
                 sb.requests, settings_tried, sb.status_seen[STAT_GRANT_FREE],
                 sb.status_seen[STAT_GRANT_RECLAIM]);
        $display("%0d refusals on a full pool, %0d free/tick/no-op requests, %0d mismatches.",
                 sb.status_seen[STAT_NONE_EXPIRED], sb.status_seen[STAT_DONE],
                 sb.error_count);
        if (sb.error_count == 0 && sb.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            if (sb.pending() > 0) $display("%0t: %0d results never arrived", $time, sb.pending());
            $display("== FAIL ==");
        end
        $finish;
    end

    // Watchdog: the slowest legal run needs well under a fifth of this.
    initial begin
        #5_000_000;
        $display("%0t: run timed out with %0d results outstanding", $time, sb.pending());
        $display("== FAIL ==");
        $finish;
    end

endmodule
